[design/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W    = 32;   // addresses, sizes
    localparam int SIZE_W    = 16;   // block size
    localparam int CNT_W     = 9;    // block count, free count
    localparam int STORE_W   = 24;   // stored block offset
    localparam int SPAN_W    = SIZE_W + CNT_W;  // pool span in bytes
    localparam int CFG_IDX_W = 2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // reset values of the config registers
    localparam logic [ADDR_W-1:0] RST_POOL_BASE   = 32'd0;
    localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = 16'd32;
    localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = 9'd256;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request
        logic eval;   // evaluate, update stack
        logic emit;   // load result registers
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic alloc_hit;  // accepted allocate, needs a stack read
    } t_status;

endpackage

[design/fbpa_ram.sv]
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [WIDTH-1:0]        i_wdata,
    input  logic [AW-1:0]           i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/fbpa_ctrl.sv]
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: idle, evaluate, stack lookup.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  fbpa_pkg::t_status i_status,
    output fbpa_pkg::t_cmd    o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_status.alloc_hit ? S_LOOK : S_IDLE;
            end
            S_LOOK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_cmd.load = start && (r_state == S_IDLE);
    assign o_cmd.eval = (r_state == S_EVAL);
    // rejects and frees finish in eval; accepted allocates wait for RAM data
    assign o_cmd.emit = ((r_state == S_EVAL) && !i_status.alloc_hit) ||
                        (r_state == S_LOOK);

endmodule

[design/fbpa_dp.sv]
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: config registers, free stack, counters, result registers.
// ----------------------------------------------------------------------------
module fbpa_dp #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fbpa_pkg::t_cmd                     i_cmd,
    output fbpa_pkg::t_status                  o_status,
    input  logic                               i_kind,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_pool_addr,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_block_addr,
    input  logic                               i_cfg_wr,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_cfg_data,
    output logic                               o_done,
    output logic                               o_ok,
    output logic [fbpa_pkg::ADDR_W-1:0]        o_addr,
    output logic [fbpa_pkg::CNT_W-1:0]         o_free_left
);
    localparam int AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = fbpa_pkg::CNT_W;
    localparam int ADDR_W = fbpa_pkg::ADDR_W;
    localparam int SIZE_W = fbpa_pkg::SIZE_W;
    localparam int ST_W   = fbpa_pkg::STORE_W;
    localparam int SPAN_W = fbpa_pkg::SPAN_W;

    function automatic logic [CNT_W-1:0] f_sat(input logic [CNT_W-1:0] bc);
        f_sat = (32'(bc) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : bc;
    endfunction

    // config
    logic [ADDR_W-1:0] r_base, n_base;
    logic [SIZE_W-1:0] r_block_size, n_block_size;
    logic [CNT_W-1:0]  r_block_count, n_block_count;
    logic [CNT_W-1:0]  r_eff;
    logic              restart;
    logic [CNT_W-1:0]  eff_new;
    logic [SPAN_W-1:0] r_span;

    // captured request
    logic              r_kind;
    logic [ADDR_W-1:0] r_pool_addr, r_req_size, r_block_addr;

    // stack state
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_low, n_low;    // low-water mark since restart
    logic [CNT_W-1:0]  pop_cnt;
    logic [AW-1:0]     pop_idx;
    logic [AW+SIZE_W-1:0] fill_prod;
    logic [ST_W-1:0]   r_fill;
    logic              r_use_fill;
    logic [ST_W-1:0]   rd_data;

    // decisions
    logic              pool_match, alloc_hit, free_hit;
    logic [ADDR_W-1:0] offset;

    // results
    logic              r_done, r_ok;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_free_left;
    logic [ADDR_W-1:0] pop_addr;

    // config decode; any listed register restarts the pool
    always_comb begin
        n_base        = r_base;
        n_block_size  = r_block_size;
        n_block_count = r_block_count;
        restart       = 1'b0;
        if (i_cfg_wr) begin
            unique case (i_cfg_index)
                fbpa_pkg::REG_POOL_BASE: begin
                    n_base  = i_cfg_data;
                    restart = 1'b1;
                end
                fbpa_pkg::REG_BLOCK_SIZE: begin
                    n_block_size = i_cfg_data[SIZE_W-1:0];
                    restart      = 1'b1;
                end
                fbpa_pkg::REG_BLOCK_COUNT: begin
                    n_block_count = i_cfg_data[CNT_W-1:0];
                    restart       = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign eff_new = f_sat(n_block_count);

    // request evaluation
    assign pool_match = (r_pool_addr == r_base);
    assign offset     = r_block_addr - r_base;
    assign alloc_hit  = (r_kind == fbpa_pkg::KIND_ALLOC) && pool_match &&
                        (r_req_size <= ADDR_W'(r_block_size)) && (r_count != '0);
    assign free_hit   = (r_kind == fbpa_pkg::KIND_FREE) && pool_match &&
                        (r_block_addr >= r_base) && (offset < ADDR_W'(r_span)) &&
                        (r_count < r_eff);

    assign o_status.alloc_hit = alloc_hit;

    assign pop_cnt   = r_count - CNT_W'(1);
    assign pop_idx   = AW'(pop_cnt);
    assign fill_prod = pop_idx * r_block_size;

    always_comb begin
        n_count = r_count;
        n_low   = r_low;
        if (restart) begin
            n_count = eff_new;
            n_low   = eff_new;
        end else if (i_cmd.eval && alloc_hit) begin
            n_count = pop_cnt;
            if (pop_cnt < r_low) n_low = pop_cnt;
        end else if (i_cmd.eval && free_hit) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    fbpa_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_BLOCKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.eval && free_hit),
        .i_waddr (AW'(r_count)),
        .i_wdata (offset[ST_W-1:0]),
        .i_raddr (pop_idx),
        .o_rdata (rd_data)
    );

    // entries below the low-water mark were never pushed: they hold i * size
    assign pop_addr = r_base + (r_use_fill ? ADDR_W'(r_fill) : ADDR_W'(rd_data));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= fbpa_pkg::RST_POOL_BASE;
            r_block_size  <= fbpa_pkg::RST_BLOCK_SIZE;
            r_block_count <= fbpa_pkg::RST_BLOCK_COUNT;
            r_eff         <= f_sat(fbpa_pkg::RST_BLOCK_COUNT);
            r_count       <= f_sat(fbpa_pkg::RST_BLOCK_COUNT);
            r_low         <= f_sat(fbpa_pkg::RST_BLOCK_COUNT);
            r_done        <= 1'b0;
        end else begin
            r_base        <= n_base;
            r_block_size  <= n_block_size;
            r_block_count <= n_block_count;
            if (restart) r_eff <= eff_new;
            r_count       <= n_count;
            r_low         <= n_low;
            r_done        <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        // span tracks the register values being loaded, valid with them
        r_span <= SPAN_W'(n_block_size) * SPAN_W'(eff_new);
        if (i_cmd.load) begin
            r_kind       <= i_kind;
            r_pool_addr  <= i_pool_addr;
            r_req_size   <= i_req_size;
            r_block_addr <= i_block_addr;
        end
        if (i_cmd.eval) begin
            r_fill     <= ST_W'(fill_prod);
            r_use_fill <= (pop_cnt < r_low);
        end
        if (i_cmd.emit) begin
            if (i_cmd.eval) begin
                r_ok        <= free_hit;
                r_addr      <= '0;
                r_free_left <= n_count;
            end else begin
                r_ok        <= 1'b1;
                r_addr      <= pop_addr;
                r_free_left <= r_count;
            end
        end
    end

    assign o_done      = r_done;
    assign o_ok        = r_ok;
    assign o_addr      = r_addr;
    assign o_free_left = r_free_left;

    a_count_le_eff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_eff)
        else $error("free count above pool size");

    a_low_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_count)
        else $error("low-water mark above free count");

    a_reject_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_addr == '0))
        else $error("rejected request returned an address");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

endmodule

[design/fixed_block_pool_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Rejects and frees: the result is loaded in the eval state; no new request is taken while busy.
// Accepted allocates: the result waits in the lookup state for the registered read of the free stack RAM.
// o_done is a one-cycle strobe; the receiver cannot stall it.
// Reset: no clearing pass, the block takes requests right after reset release.
// ----------------------------------------------------------------------------
//
// One pool of fixed-size blocks. Free block offsets live on a LIFO stack in
// a RAM, with a free counter as the stack pointer. An allocate pops the top
// offset and returns pool_base + offset; a free pushes block_addr - pool_base.
//
// Restart (any write to pool_base, block_size or block_count, and reset)
// logically sets entry i to i * block_size. Instead of sweeping the RAM, a
// low-water mark tracks the lowest stack depth reached since restart: any
// entry below it was never pushed, so a pop there uses i * block_size from a
// multiplier rather than the RAM data. Entries at or above it were pushed.
//
// Config channel is always ready; a transfer to an index past the register
// list is ignored and does not restart the pool. Config is expected only
// while idle.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_kind,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_pool_addr,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_block_addr,
    // result strobe
    output logic                               o_done,
    output logic                               o_ok,
    output logic [fbpa_pkg::ADDR_W-1:0]        o_addr,
    output logic [fbpa_pkg::CNT_W-1:0]         o_free_left,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]        i_cfg_data
);
    fbpa_pkg::t_cmd    cmd;
    fbpa_pkg::t_status status;

    // register writes are never back-pressured
    assign o_cfg_ready = 1'b1;

    // sequencer: idle -> eval -> (lookup for accepted allocates) -> idle
    fbpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // config, stack RAM, counters and result registers
    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_pool_addr  (i_pool_addr),
        .i_req_size   (i_req_size),
        .i_block_addr (i_block_addr),
        .i_cfg_wr     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_ok         (o_ok),
        .o_addr       (o_addr),
        .o_free_left  (o_free_left)
    );

endmodule
